@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fmmt_pkg.sv @@
// shared types and codes for the min/max tracking queue
package fmmt_pkg;

    localparam int DATA_W = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic push;
        logic shift;
    } cell_ctl_t;

endpackage

@@ rtl/fifo_with_min_max_tracking_top.sv @@
// queue of signed words built from a row of cells, with running max, min and count
// latency: push or plain pop has its result registered in the cycle after the request
// a pop that removes the max or min rotates the cell row once to rescan the remaining entries
// throughput: 1 request per cycle while the output is not stalled; no request is taken during a rescan
// reset: synchronous active-low aresetn empties the queue and zeroes max, min, count
module fifo_with_min_max_tracking_top #(
    parameter int DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  fmmt_pkg::word_t        s_data_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [4:0]             m_entry_count,
    output fmmt_pkg::word_t        m_max_value,
    output fmmt_pkg::word_t        m_min_value
);
    import fmmt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic            state_reg, state_next;
    logic [SW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]   count_reg, count_next;
    word_t           max_reg, max_next;
    word_t           min_reg, min_next;
    word_t           hi_reg, hi_next;
    word_t           lo_reg, lo_next;

    logic            m_valid_reg, m_valid_next;
    logic [1:0]      status_reg, status_next;
    logic [CW-1:0]   ocount_reg, ocount_next;
    word_t           omax_reg, omax_next;
    word_t           omin_reg, omin_next;

    cell_ctl_t       ctl;
    word_t           cell_data  [DEPTH];
    logic            cell_valid [DEPTH];
    word_t           head;
    word_t           cand_hi, cand_lo;
    logic            accept;
    logic            scan_first, scan_last;
    logic [CW+4:0]   count_ext;

    // row of cells; the last one takes the head back while rotating
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  pv;
        logic  nv;
        word_t nd;
        if (i == 0) begin : g_first
            assign pv = 1'b1;
        end else begin : g_inner
            assign pv = cell_valid[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign nd = cell_data[0];
            assign nv = (state_reg == S_SCAN) ? cell_valid[0] : 1'b0;
        end else begin : g_mid
            assign nd = cell_data[i+1];
            assign nv = cell_valid[i+1];
        end
        fmmt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .push_data  (s_data_word),
            .prev_valid (pv),
            .next_data  (nd),
            .next_valid (nv),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
        );
    end

    assign head       = cell_data[0];
    assign s_ready    = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign scan_first = (scan_cnt_reg == '0);
    assign scan_last  = (scan_cnt_reg == SW'(DEPTH - 1));

    always_comb begin
        cand_hi = hi_reg;
        cand_lo = lo_reg;
        if (scan_first) begin
            cand_hi = head;
            cand_lo = head;
        end else if (cell_valid[0]) begin
            if (head > hi_reg) cand_hi = head;
            if (head < lo_reg) cand_lo = head;
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        max_next      = max_reg;
        min_next      = min_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        ocount_next   = ocount_reg;
        omax_next     = omax_reg;
        omin_next     = omin_reg;
        ctl.push      = 1'b0;
        ctl.shift     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_PUSH) begin
                        if (count_reg == CW'(DEPTH)) begin
                            m_valid_next = 1'b1;
                            status_next  = STATUS_FULL;
                            ocount_next  = count_reg;
                            omax_next    = max_reg;
                            omin_next    = min_reg;
                        end else begin
                            ctl.push   = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0) begin
                                max_next = s_data_word;
                                min_next = s_data_word;
                            end else begin
                                if (s_data_word > max_reg) max_next = s_data_word;
                                if (s_data_word < min_reg) min_next = s_data_word;
                            end
                            m_valid_next = 1'b1;
                            status_next  = STATUS_OK;
                            ocount_next  = count_next;
                            omax_next    = max_next;
                            omin_next    = min_next;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            m_valid_next = 1'b1;
                            status_next  = STATUS_EMPTY;
                            ocount_next  = '0;
                            omax_next    = '0;
                            omin_next    = '0;
                        end else begin
                            ctl.shift  = 1'b1;
                            count_next = count_reg - 1'b1;
                            if (count_reg == CW'(1)) begin
                                max_next     = '0;
                                min_next     = '0;
                                m_valid_next = 1'b1;
                                status_next  = STATUS_OK;
                                ocount_next  = '0;
                                omax_next    = '0;
                                omin_next    = '0;
                            end else if (head == max_reg || head == min_reg) begin
                                state_next    = S_SCAN;
                                scan_cnt_next = '0;
                            end else begin
                                m_valid_next = 1'b1;
                                status_next  = STATUS_OK;
                                ocount_next  = count_next;
                                omax_next    = max_reg;
                                omin_next    = min_reg;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                // full rotation of the row brings every cell past the head once
                ctl.shift     = 1'b1;
                hi_next       = cand_hi;
                lo_next       = cand_lo;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_last) begin
                    state_next    = S_IDLE;
                    scan_cnt_next = '0;
                    max_next      = cand_hi;
                    min_next      = cand_lo;
                    m_valid_next  = 1'b1;
                    status_next   = STATUS_OK;
                    ocount_next   = count_reg;
                    omax_next     = cand_hi;
                    omin_next     = cand_lo;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            max_reg      <= '0;
            min_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
        omax_reg   <= omax_next;
        omin_reg   <= omin_next;
    end

    assign count_ext     = {5'b0, ocount_reg};
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = count_ext[4:0];
    assign m_max_value   = omax_reg;
    assign m_min_value   = omin_reg;

endmodule

@@ rtl/fmmt_cell.sv @@
// one queue cell: loads on push when it is the first free slot, shifts from its neighbor
module fmmt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  fmmt_pkg::cell_ctl_t ctl,
    input  fmmt_pkg::word_t     push_data,
    input  logic                prev_valid,
    input  fmmt_pkg::word_t     next_data,
    input  logic                next_valid,
    output fmmt_pkg::word_t     data,
    output logic                valid
);
    import fmmt_pkg::*;

    word_t data_reg;
    logic  valid_reg;
    logic  load;

    assign load  = ctl.push && prev_valid && !valid_reg;
    assign data  = data_reg;
    assign valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.shift) begin
            valid_reg <= next_valid;
        end else if (load) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            data_reg <= next_data;
        end else if (load) begin
            data_reg <= push_data;
        end
    end

endmodule

@@ rtl/fmmt_checker.sv @@
// port-level checks for the min/max tracking queue, bound to the top level
`include "assert_macros.svh"

module fmmt_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_mode,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_status,
    input logic [4:0]             m_entry_count,
    input fmmt_pkg::word_t        m_max_value,
    input fmmt_pkg::word_t        m_min_value
);
    import fmmt_pkg::*;

    logic [70:0] m_payload;
    logic        status_known;
    logic        empty_zero;
    logic        m_holding;
    logic        push_taken;

    assign m_payload    = {m_status, m_entry_count, m_max_value, m_min_value};
    assign status_known = (m_status == STATUS_OK) || (m_status == STATUS_EMPTY) ||
                          (m_status == STATUS_FULL);
    assign empty_zero   = (m_entry_count == 5'd0) && (m_max_value == '0) &&
                          (m_min_value == '0);
    assign m_holding    = m_valid && (m_entry_count != 5'd0);
    assign push_taken   = s_valid && s_ready && (s_mode == MODE_PUSH);

    `ASSERT_NEXT(a_hold_stall, aclk, aresetn, (m_valid && !m_ready), (m_valid && $stable(m_payload)))
    `ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, status_known)
    `ASSERT_SAME(a_empty_zero, aclk, aresetn, (m_valid && m_status == STATUS_EMPTY), empty_zero)
    `ASSERT_SAME(a_max_ge_min, aclk, aresetn, m_holding, (m_max_value >= m_min_value))
    `ASSERT_NEXT(a_push_result, aclk, aresetn, push_taken, m_valid)

endmodule

bind fifo_with_min_max_tracking_top fmmt_checker u_fmmt_checker (.*);
